// ===== design/tlvp_pkg.sv =====
// shared types, constants and codes of the type-length-value packet parser
// no dependencies; imported by every module of the block
package tlvp_pkg;

  // packet layout
  localparam int HEADER_BYTES    = 18;
  localparam int FIELD_HDR_BYTES = 6;
  localparam int MAX_TRAILING    = 8;
  localparam int CMD_END_POS     = 3;
  localparam int TXN_END_POS     = 7;
  localparam int BODY_END_POS    = 11;
  localparam int RSV_END_POS     = 15;
  localparam int HDR_END_POS     = HEADER_BYTES - 1;

  // widths
  localparam int POS_W    = 25;
  localparam int SHIFT_W  = 48;
  localparam int MAXB_W   = 24;
  localparam int MAXF_W   = 16;
  localparam int FHI_W    = 3;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;
  localparam int TDATA_W  = 216;

  // reset values of the limit registers
  localparam logic [MAXB_W-1:0] MAX_BODY_RST  = 24'd1048576;
  localparam logic [MAXF_W-1:0] MAX_FIELD_RST = 16'd64;

  // default depth of the result queue
  localparam int RES_DEPTH_DEF = 8;

  // register map, indexed by paddr[2]
  typedef enum logic {
    REG_MAX_BODY  = 1'b0,
    REG_MAX_FIELD = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_FIELD   = 2'd1,
    EV_VALUE   = 2'd2,
    EV_VERDICT = 2'd3
  } ev_kind_e;

  typedef enum logic [3:0] {
    VD_OK           = 4'd0,
    VD_SHORT        = 4'd1,
    VD_BODY_LIMIT   = 4'd2,
    VD_FIELD_LIMIT  = 4'd3,
    VD_BODY_PAST    = 4'd4,
    VD_FHDR_OVERRUN = 4'd5,
    VD_VALUE_OVERRUN= 4'd6,
    VD_NOT_FILLED   = 4'd7,
    VD_TRAILING     = 4'd8
  } verdict_e;

  typedef struct packed {
    logic [MAXB_W-1:0] max_body;
    logic [MAXF_W-1:0] max_field;
  } cfg_t;

  typedef struct packed {
    ev_kind_e     kind;
    logic [31:0]  command_word;
    logic [31:0]  transaction_word;
    logic [31:0]  reserved_word;
    logic [15:0]  declared_fields;
    logic [15:0]  field_number;
    logic [31:0]  field_type;
    logic [15:0]  field_length;
    logic [7:0]   value_byte;
    verdict_e     verdict_code;
    logic [POS_W-1:0] packet_length;
    logic         last_of_run;
  } result_t;

  // up to two results per input byte, first one in slot a
  typedef struct packed {
    logic [1:0] cnt;
    result_t    a;
    result_t    b;
  } push_t;

endpackage

// ===== design/tlvp_regs.sv =====
// limit registers behind the apb-style configuration port
// depends on tlvp_pkg
module tlvp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tlvp_pkg::APB_AW-1:0]  paddr,
  input  logic [tlvp_pkg::APB_DW-1:0]  pwdata,
  output logic [tlvp_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output tlvp_pkg::cfg_t               cfg_o
);
  import tlvp_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_body  <= MAX_BODY_RST;
      cfg_q.max_field <= MAX_FIELD_RST;
    end else if (wr_en) begin
      if (reg_idx_e'(paddr[2]) == REG_MAX_FIELD) begin
        cfg_q.max_field <= pwdata[MAXF_W-1:0];
      end else begin
        cfg_q.max_body <= pwdata[MAXB_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx_e'(paddr[2]) == REG_MAX_FIELD) begin
      prdata = {{(APB_DW-MAXF_W){1'b0}}, cfg_q.max_field};
    end else begin
      prdata = {{(APB_DW-MAXB_W){1'b0}}, cfg_q.max_body};
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/tlvp_core.sv =====
// input register, parse state and per-byte result logic
// depends on tlvp_pkg
module tlvp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      data_byte_i,
  input  logic            is_last_i,
  input  tlvp_pkg::cfg_t  cfg_i,
  output logic            busy_o,
  output tlvp_pkg::push_t push_o
);
  import tlvp_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // input register
  logic       in_valid_q;
  logic [7:0] data_q;
  logic       last_q;

  // parse state
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [31:0]        body_q, body_d;
  logic [15:0]        fe_q, fe_d;
  logic [15:0]        done_q, done_d;
  logic [FHI_W-1:0]   fhi_q, fhi_d;
  logic [31:0]        type_q, type_d;
  logic [15:0]        vrem_q, vrem_d;
  verdict_e           err_q, err_d;
  logic [31:0]        cmd_q, cmd_d;
  logic [31:0]        txn_q, txn_d;
  logic [31:0]        rsv_q, rsv_d;
  logic [15:0]        flen_q, flen_d;

  logic               in_header;
  logic [POS_W-1:0]   consumed;
  logic [32:0]        body_rem;
  logic               bnd;
  logic               have_main;
  result_t            main_res;
  result_t            vd_res;
  verdict_e           code;
  logic [32:0]        end_len;
  logic [32:0]        len_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      data_q <= data_byte_i;
      last_q <= is_last_i;
    end
  end

  assign busy_o    = in_valid_q;
  assign in_header = pos_q < POS_W'(HEADER_BYTES);
  // body bytes consumed through this byte; zero on the last header byte
  assign consumed  = in_header ? '0 : pos_q - POS_W'(HDR_END_POS);
  assign body_rem  = {1'b0, body_q} - {8'b0, consumed};

  always_comb begin
    pos_d   = pos_q;
    shift_d = shift_q;
    body_d  = body_q;
    fe_d    = fe_q;
    done_d  = done_q;
    fhi_d   = fhi_q;
    type_d  = type_q;
    vrem_d  = vrem_q;
    err_d   = err_q;
    cmd_d   = cmd_q;
    txn_d   = txn_q;
    rsv_d   = rsv_q;
    flen_d  = flen_q;
    bnd       = 1'b0;
    have_main = 1'b0;
    main_res  = '0;
    vd_res    = '0;
    code      = VD_OK;
    end_len   = '0;
    len_ext   = '0;
    push_o    = '0;

    if (in_valid_q) begin
      if (in_header) begin
        shift_d = {shift_q[SHIFT_W-9:0], data_q};
        if (pos_q == POS_W'(CMD_END_POS)) begin
          cmd_d = shift_d[31:0];
        end else if (pos_q == POS_W'(TXN_END_POS)) begin
          txn_d = shift_d[31:0];
        end else if (pos_q == POS_W'(BODY_END_POS)) begin
          body_d = shift_d[31:0];
        end else if (pos_q == POS_W'(RSV_END_POS)) begin
          rsv_d = shift_d[31:0];
        end else if (pos_q == POS_W'(HDR_END_POS)) begin
          fe_d                      = shift_d[15:0];
          have_main                 = 1'b1;
          main_res.kind             = EV_HEADER;
          main_res.command_word     = cmd_q;
          main_res.transaction_word = txn_q;
          main_res.reserved_word    = rsv_q;
          main_res.declared_fields  = fe_d;
          shift_d                   = '0;
          bnd                       = 1'b1;
        end
      end else if (pos_q != POS_MAX && err_q == VD_OK && done_q < fe_q) begin
        if (vrem_q != '0) begin
          have_main             = 1'b1;
          main_res.kind         = EV_VALUE;
          main_res.field_number = done_q;
          main_res.field_type   = type_q;
          main_res.field_length = flen_q;
          main_res.value_byte   = data_q;
          vrem_d                = vrem_q - 16'd1;
          if (vrem_q == 16'd1) begin
            done_d = done_q + 16'd1;
            bnd    = 1'b1;
          end
        end else begin
          shift_d = {shift_q[SHIFT_W-9:0], data_q};
          if (fhi_q == FHI_W'(FIELD_HDR_BYTES - 1)) begin
            fhi_d                 = '0;
            type_d                = shift_d[47:16];
            flen_d                = shift_d[15:0];
            have_main             = 1'b1;
            main_res.kind         = EV_FIELD;
            main_res.field_number = done_q;
            main_res.field_type   = type_d;
            main_res.field_length = flen_d;
            if ({17'b0, flen_d} > body_rem) begin
              err_d = VD_VALUE_OVERRUN;
            end else if (flen_d == '0) begin
              done_d = done_q + 16'd1;
              bnd    = 1'b1;
            end else begin
              vrem_d = flen_d;
            end
          end else begin
            fhi_d = fhi_q + FHI_W'(1);
          end
        end
      end

      // field boundary: all fields done, or room for another field header
      if (bnd) begin
        if (done_d >= fe_d) begin
          if (body_rem != '0) begin
            err_d = VD_NOT_FILLED;
          end
        end else if (body_rem < 33'(FIELD_HDR_BYTES)) begin
          err_d = VD_FHDR_OVERRUN;
        end
      end

      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end

      main_res.last_of_run = ~last_q;

      if (last_q) begin
        len_ext = {8'b0, pos_d};
        end_len = 33'(HEADER_BYTES) + {1'b0, body_d};
        if (pos_d < POS_W'(HEADER_BYTES)) begin
          code = VD_SHORT;
        end else if (body_d > {8'b0, cfg_i.max_body}) begin
          code = VD_BODY_LIMIT;
        end else if (fe_d > cfg_i.max_field) begin
          code = VD_FIELD_LIMIT;
        end else if (end_len > len_ext) begin
          code = VD_BODY_PAST;
        end else if (err_d != VD_OK) begin
          code = err_d;
        end else if ((len_ext - end_len) > 33'(MAX_TRAILING)) begin
          code = VD_TRAILING;
        end
        vd_res.kind          = EV_VERDICT;
        vd_res.verdict_code  = code;
        vd_res.packet_length = (code == VD_OK) ? end_len[POS_W-1:0] : '0;
        vd_res.last_of_run   = 1'b1;
        if (have_main) begin
          push_o.cnt = 2'd2;
          push_o.a   = main_res;
          push_o.b   = vd_res;
        end else begin
          push_o.cnt = 2'd1;
          push_o.a   = vd_res;
        end
        // back to reset for the next packet
        pos_d   = '0;
        shift_d = '0;
        body_d  = '0;
        fe_d    = '0;
        done_d  = '0;
        fhi_d   = '0;
        type_d  = '0;
        vrem_d  = '0;
        err_d   = VD_OK;
        cmd_d   = '0;
        txn_d   = '0;
        rsv_d   = '0;
        flen_d  = '0;
      end else if (have_main) begin
        push_o.cnt = 2'd1;
        push_o.a   = main_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      shift_q <= '0;
      body_q  <= '0;
      fe_q    <= '0;
      done_q  <= '0;
      fhi_q   <= '0;
      type_q  <= '0;
      vrem_q  <= '0;
      err_q   <= VD_OK;
      cmd_q   <= '0;
      txn_q   <= '0;
      rsv_q   <= '0;
      flen_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      shift_q <= shift_d;
      body_q  <= body_d;
      fe_q    <= fe_d;
      done_q  <= done_d;
      fhi_q   <= fhi_d;
      type_q  <= type_d;
      vrem_q  <= vrem_d;
      err_q   <= err_d;
      cmd_q   <= cmd_d;
      txn_q   <= txn_d;
      rsv_q   <= rsv_d;
      flen_q  <= flen_d;
    end
  end

endmodule

// ===== design/tlvp_fifo.sv =====
// result queue: takes up to two results a cycle, hands out one
// depends on tlvp_pkg
module tlvp_fifo #(
  parameter int DEPTH = tlvp_pkg::RES_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tlvp_pkg::push_t              push_i,
  input  logic                         pop_i,
  output logic                         valid_o,
  output tlvp_pkg::result_t            head_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  import tlvp_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t         mem [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [PW-1:0]   wr_next;
  logic [CW-1:0]   cnt_q, cnt_d;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_next = wrap_inc(wr_q);

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i.cnt == 2'd2) begin
      wr_d = wrap_inc(wr_next);
    end else if (push_i.cnt == 2'd1) begin
      wr_d = wr_next;
    end
    if (pop_i) begin
      rd_d = wrap_inc(rd_q);
    end
    cnt_d = cnt_q + CW'(push_i.cnt) - CW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem[wr_q] <= push_i.a;
    end
    if (push_i.cnt == 2'd2) begin
      mem[wr_next] <= push_i.b;
    end
  end

  assign valid_o = cnt_q != '0;
  assign head_o  = mem[rd_q];
  assign count_o = cnt_q;

endmodule

// ===== design/tlv_packet_parser.sv =====
// the results of a byte pass the core's input register and then the result queue; the
// verdict of a byte that also gives a header, field or value result leaves after it
// throughput: one byte per cycle; s_axis_tready drops while the queued results, plus two for a
// byte in the core, exceed RES_DEPTH - 4; one result leaves per cycle with m_axis_tready
// reset: asynchronous, active low; clears parse state and queue, limit registers to defaults
// top level of the streaming type-length-value packet parser, needs tlvp_pkg
module tlv_packet_parser #(
  // result queue depth, at least 4
  parameter int RES_DEPTH = tlvp_pkg::RES_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // packet byte stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // is_last
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] command_word, [63:32] transaction_word, [95:64] reserved_word,
  // [111:96] declared_fields, [127:112] field_number, [159:128] field_type,
  // [175:160] field_length, [183:176] value_byte, [187:184] verdict_code,
  // [212:188] packet_length, [215:213] zero
  output logic [tlvp_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // [1:0] event_kind
  output logic                          m_axis_tlast,  // last_of_run
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlvp_pkg::APB_AW-1:0]   paddr,
  input  logic [tlvp_pkg::APB_DW-1:0]   pwdata,
  output logic [tlvp_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import tlvp_pkg::*;

  localparam int CW = $clog2(RES_DEPTH + 1);

  cfg_t            cfg;
  push_t           push;
  result_t         head;
  logic            busy;
  logic            in_acc;
  logic            out_acc;
  logic [CW-1:0]   q_count;
  logic [CW:0]     q_load;

  // limit registers
  tlvp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a byte transaction lands in the core's input register, is parsed in the
  // next cycle and its results go straight into the queue
  assign in_acc = s_axis_tvalid & s_axis_tready;

  tlvp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (s_axis_tdata),
    .is_last_i   (s_axis_tlast),
    .cfg_i       (cfg),
    .busy_o      (busy),
    .push_o      (push)
  );

  // worst case the byte in the core and the byte taken now push two results
  // each, so keep room for four beyond what is queued and in flight
  assign q_load        = {1'b0, q_count} + (busy ? (CW+1)'(2) : '0);
  assign s_axis_tready = q_load <= (CW+1)'(RES_DEPTH - 4);

  assign out_acc = m_axis_tvalid & m_axis_tready;

  tlvp_fifo #(
    .DEPTH (RES_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_acc),
    .valid_o (m_axis_tvalid),
    .head_o  (head),
    .count_o (q_count)
  );

  // pack the result fields, first field lowest
  assign m_axis_tdata = {3'b000,
                         head.packet_length,
                         head.verdict_code,
                         head.value_byte,
                         head.field_length,
                         head.field_type,
                         head.field_number,
                         head.declared_fields,
                         head.reserved_word,
                         head.transaction_word,
                         head.command_word};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last_of_run;

  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CW'(RES_DEPTH))
    else $error("result queue overfilled");

  // a verdict always closes the run of its byte
  a_verdict_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == EV_VERDICT) |-> m_axis_tlast)
    else $error("verdict without last mark");

  // a byte with two results has its verdict second
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (push.b.kind == EV_VERDICT && push.a.kind != EV_VERDICT))
    else $error("bad result pair order");

  // results only follow a byte held in the core
  a_push_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt != 2'd0) |-> busy)
    else $error("result without a byte");

endmodule

// ===== tb/sv/tlvp_event_checker.sv =====
// checker for the type-length-value packet parser: follows the byte stream,
// the limit registers and the result stream, predicts every result and compares
// needs tlvp_pkg; instantiated beside the block by tb_tlv_packet_parser
module tlvp_event_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // is_last
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] command_word, [63:32] transaction_word, [95:64] reserved_word,
  // [111:96] declared_fields, [127:112] field_number, [159:128] field_type,
  // [175:160] field_length, [183:176] value_byte, [187:184] verdict_code,
  // [212:188] packet_length, [215:213] zero
  input  logic [tlvp_pkg::TDATA_W-1:0]  m_axis_tdata,
  input  logic [1:0]                    m_axis_tuser,  // [1:0] event_kind
  input  logic                          m_axis_tlast,  // last_of_run
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlvp_pkg::APB_AW-1:0]   paddr,
  input  logic [tlvp_pkg::APB_DW-1:0]   pwdata,
  input  logic [tlvp_pkg::APB_DW-1:0]   prdata,
  input  logic                          pready,
  output int                            fail_cnt_o,
  output int                            pending_o,
  output int                            checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import tlvp_pkg::*;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  // limit registers as the block should hold them
  logic [MAXB_W-1:0]  lim_body;
  logic [MAXF_W-1:0]  lim_field;

  // parse state of the packet in flight
  logic [POS_W-1:0]   pos;
  logic [SHIFT_W-1:0] hdr_sr;
  logic [31:0]        body_len;
  logic [15:0]        fld_expected;
  logic [15:0]        fld_done;
  logic [FHI_W-1:0]   fhi;
  logic [31:0]        cur_type;
  logic [15:0]        cur_len;
  logic [15:0]        val_left;
  verdict_e           first_err;
  logic [31:0]        cmd_w;
  logic [31:0]        txn_w;
  logic [31:0]        rsv_w;

  result_t            expected_events [$];
  int                 n_fail;
  int                 n_checked;

  function automatic void clear_packet();
    pos          = '0;
    hdr_sr       = '0;
    body_len     = '0;
    fld_expected = '0;
    fld_done     = '0;
    fhi          = '0;
    cur_type     = '0;
    cur_len      = '0;
    val_left     = '0;
    first_err    = VD_OK;
    cmd_w        = '0;
    txn_w        = '0;
    rsv_w        = '0;
  endfunction

  // at a field boundary: either the walk is complete or another header must fit
  function automatic void field_boundary(input longint unsigned used);
    longint unsigned rest;
    rest = longint'(body_len) - used;
    if (fld_done >= fld_expected) begin
      if (rest != 0) first_err = VD_NOT_FILLED;
    end else if (rest < FIELD_HDR_BYTES) begin
      first_err = VD_FHDR_OVERRUN;
    end
  endfunction

  // advances the parse by one byte and queues the events it gives
  function automatic void walk_packet_byte(input logic [7:0] b, input logic last);
    result_t          ev [2];
    int               n;
    logic [POS_W-1:0] p;
    longint unsigned  used;
    longint unsigned  room;
    longint unsigned  pkt_len;
    longint unsigned  pkt_end;
    verdict_e         code;
    n     = 0;
    p     = pos;
    ev[0] = '0;
    ev[1] = '0;
    if (p < HEADER_BYTES) begin
      hdr_sr = {hdr_sr[SHIFT_W-9:0], b};
      case (p)
        CMD_END_POS:  cmd_w    = hdr_sr[31:0];
        TXN_END_POS:  txn_w    = hdr_sr[31:0];
        BODY_END_POS: body_len = hdr_sr[31:0];
        RSV_END_POS:  rsv_w    = hdr_sr[31:0];
        HDR_END_POS: begin
          fld_expected           = hdr_sr[15:0];
          ev[n].kind             = EV_HEADER;
          ev[n].command_word     = cmd_w;
          ev[n].transaction_word = txn_w;
          ev[n].reserved_word    = rsv_w;
          ev[n].declared_fields  = fld_expected;
          n++;
          hdr_sr = '0;
          field_boundary(0);
        end
        default: ;
      endcase
    end else if (p < POS_MAX && first_err == VD_OK && fld_done < fld_expected) begin
      used = longint'(p) + 1 - HEADER_BYTES;
      if (val_left != 0) begin
        ev[n].kind         = EV_VALUE;
        ev[n].field_number = fld_done;
        ev[n].field_type   = cur_type;
        ev[n].field_length = cur_len;
        ev[n].value_byte   = b;
        n++;
        val_left--;
        if (val_left == 0) begin
          fld_done++;
          field_boundary(used);
        end
      end else begin
        hdr_sr = {hdr_sr[SHIFT_W-9:0], b};
        fhi++;
        if (fhi >= FIELD_HDR_BYTES) begin
          room               = longint'(body_len) - used;
          fhi                = '0;
          cur_type           = hdr_sr[47:16];
          cur_len            = hdr_sr[15:0];
          ev[n].kind         = EV_FIELD;
          ev[n].field_number = fld_done;
          ev[n].field_type   = cur_type;
          ev[n].field_length = cur_len;
          n++;
          if (cur_len > room) begin
            first_err = VD_VALUE_OVERRUN;
          end else if (cur_len == 0) begin
            fld_done++;
            field_boundary(used);
          end else begin
            val_left = cur_len;
          end
        end
      end
    end
    if (p < POS_MAX) pos = p + 1'b1;
    if (last) begin
      pkt_len = pos;
      pkt_end = longint'(body_len) + HEADER_BYTES;
      if (pkt_len < HEADER_BYTES)                code = VD_SHORT;
      else if (body_len > lim_body)              code = VD_BODY_LIMIT;
      else if (fld_expected > lim_field)         code = VD_FIELD_LIMIT;
      else if (pkt_end > pkt_len)                code = VD_BODY_PAST;
      else if (first_err != VD_OK)               code = first_err;
      else if (pkt_len - pkt_end > MAX_TRAILING) code = VD_TRAILING;
      else                                       code = VD_OK;
      ev[n].kind          = EV_VERDICT;
      ev[n].verdict_code  = code;
      ev[n].packet_length = (code == VD_OK) ? pkt_end[POS_W-1:0] : '0;
      n++;
      clear_packet();
    end
    if (n > 0) ev[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(ev[i]);
  endfunction

  function automatic void cmp_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
    if (want !== got) begin
      n_fail++;
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_packet();
      lim_body  = MAX_BODY_RST;
      lim_field = MAX_FIELD_RST;
      expected_events.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // register access phase
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_e'(paddr[2]))
            REG_MAX_BODY:  lim_body  = pwdata[MAXB_W-1:0];
            REG_MAX_FIELD: lim_field = pwdata[MAXF_W-1:0];
            default: ;
          endcase
        end else begin
          case (reg_idx_e'(paddr[2]))
            REG_MAX_BODY:  cmp_field("prdata max_body_length", 64'(lim_body), prdata);
            REG_MAX_FIELD: cmp_field("prdata max_field_count", 64'(lim_field), prdata);
            default: ;
          endcase
        end
      end
      if (s_axis_tvalid && s_axis_tready) walk_packet_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_events.size() == 0) begin
          n_fail++;
          $error("result of kind %0d arrived with nothing expected", m_axis_tuser);
        end else begin
          want = expected_events.pop_front();
          n_checked++;
          cmp_field("event_kind",       want.kind,             m_axis_tuser);
          cmp_field("command_word",     want.command_word,     m_axis_tdata[31:0]);
          cmp_field("transaction_word", want.transaction_word, m_axis_tdata[63:32]);
          cmp_field("reserved_word",    want.reserved_word,    m_axis_tdata[95:64]);
          cmp_field("declared_fields",  want.declared_fields,  m_axis_tdata[111:96]);
          cmp_field("field_number",     want.field_number,     m_axis_tdata[127:112]);
          cmp_field("field_type",       want.field_type,       m_axis_tdata[159:128]);
          cmp_field("field_length",     want.field_length,     m_axis_tdata[175:160]);
          cmp_field("value_byte",       want.value_byte,       m_axis_tdata[183:176]);
          cmp_field("verdict_code",     want.verdict_code,     m_axis_tdata[187:184]);
          cmp_field("packet_length",    want.packet_length,    m_axis_tdata[212:188]);
          cmp_field("tdata padding",    '0,                    m_axis_tdata[215:213]);
          cmp_field("last_of_run",      want.last_of_run,      m_axis_tlast);
        end
      end
    end
    fail_cnt_o <= n_fail;
    pending_o  <= expected_events.size();
    checked_o  <= n_checked;
  end

endmodule

// ===== tb/sv/tb_tlv_packet_parser.sv =====
// top of the type-length-value packet parser testbench: clock, reset, packet
// stimulus, register accesses and the verdict; needs tlvp_pkg, tlv_packet_parser
// and tlvp_event_checker, which does all prediction and comparison
module tb_tlv_packet_parser;
  timeunit 1ns;
  timeprecision 1ps;
  import tlvp_pkg::*;

  localparam int PHASE_BYTES = 75;    // random bytes per limit setting
  localparam int SETTLE      = 10;    // cycles allowed after the last result
  localparam int QUIET_LIMIT = 2000;  // cycles with no transaction before giving up

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // byte stream
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // [7:0] data_byte
  logic                   s_axis_tlast  = 1'b0;  // is_last
  // result stream
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [31:0] command_word, [63:32] transaction_word, [95:64] reserved_word,
  // [111:96] declared_fields, [127:112] field_number, [159:128] field_type,
  // [175:160] field_length, [183:176] value_byte, [187:184] verdict_code,
  // [212:188] packet_length, [215:213] zero
  logic [TDATA_W-1:0]     m_axis_tdata;
  logic [1:0]             m_axis_tuser;  // [1:0] event_kind
  logic                   m_axis_tlast;  // last_of_run
  // register port
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_AW-1:0]      paddr   = '0;
  logic [APB_DW-1:0]      pwdata  = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  int   fail_cnt;
  int   pending;
  int   n_checked;
  int   n_bytes   = 0;
  int   n_packets = 0;
  int   quiet     = 0;
  logic calm      = 1'b0;  // no idling on either side while set

  logic [7:0] pkt_q [$];   // bytes of the packet being built

  always #2 clk_i = ~clk_i;

  tlv_packet_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  tlvp_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .checked_o     (n_checked)
  );

  // result side back-pressure: ready is low about 18 percent of the time unless calm
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 18);
  end

  // watchdog: any transaction on either stream or the register port resets it
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // packet building: multi-byte words go out most significant byte first
  function automatic void put_be(input logic [31:0] v, input int nb);
    for (int i = nb - 1; i >= 0; i--) pkt_q.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_fill(input int nb);
    for (int i = 0; i < nb; i++) pkt_q.push_back(8'($urandom()));
  endfunction

  function automatic void put_header(input logic [31:0] cmd, input logic [31:0] txn,
                                     input logic [31:0] body, input logic [31:0] rsv,
                                     input logic [15:0] nfld);
    put_be(cmd, 4);
    put_be(txn, 4);
    put_be(body, 4);
    put_be(rsv, 4);
    put_be(nfld, 2);
  endfunction

  // field header with a given length word, then nval random value bytes
  function automatic void put_field(input logic [31:0] ftype, input logic [15:0] len_word,
                                    input int nval);
    put_be(ftype, 4);
    put_be(len_word, 2);
    put_fill(nval);
  endfunction

  // one byte transaction, with random idle cycles ahead of it unless calm
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_bytes++;
  endtask

  // sends the built packet with tlast on its final byte
  task automatic send_packet();
    foreach (pkt_q[i]) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    pkt_q.delete();
    n_packets++;
  endtask

  // setup cycle then access cycle; an idle cycle follows so psel never toggles in one step
  task automatic apb_xfer(input logic wr, input reg_idx_e idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop sending and let every expected result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // limits are only changed with the parser idle; both are read back
  task automatic set_limits(input logic [31:0] body_v, input logic [31:0] field_v);
    drain();
    apb_xfer(1'b1, REG_MAX_BODY, body_v);
    apb_xfer(1'b1, REG_MAX_FIELD, field_v);
    apb_xfer(1'b0, REG_MAX_BODY, '0);
    apb_xfer(1'b0, REG_MAX_FIELD, '0);
  endtask

  // mostly well-formed random packets, the rest defective; padding can pass the allowance
  task automatic send_random_packet();
    int unsigned pick;
    int unsigned nf;
    int unsigned cut;
    int unsigned vlen [4];
    logic [31:0] body;
    logic [15:0] decl;
    logic [15:0] len_word;
    pick = $urandom_range(99);
    if (pick >= 95) begin
      // noise: random bytes, usually too short or an absurd header
      put_fill($urandom_range(1, 30));
    end else begin
      nf   = $urandom_range(0, 3);
      body = '0;
      for (int i = 0; i < nf; i++) begin
        vlen[i] = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
        body    = body + FIELD_HDR_BYTES + vlen[i];
      end
      decl = 16'(nf);
      if (pick >= 70 && pick < 75) begin
        // wrong field count, sometimes wildly so
        decl = $urandom_range(1) ? 16'($urandom_range(65535)) : 16'($urandom_range(0, 5));
      end else if (pick >= 75 && pick < 80) begin
        body = $urandom_range(0, body + 8);
      end else if (pick >= 80 && pick < 85) begin
        body = $urandom();
      end
      put_header($urandom(), $urandom(), body, $urandom(), decl);
      for (int i = 0; i < nf; i++) begin
        len_word = 16'(vlen[i]);
        // corrupt length word of the first field, value bytes unchanged
        if (pick >= 85 && pick < 90 && i == 0) len_word = 16'($urandom_range(65535));
        put_field($urandom(), len_word, vlen[i]);
      end
      // padding, now and then past the allowance
      put_fill(($urandom_range(9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8));
      if (pick >= 90) begin
        // truncated buffer: tlast lands anywhere in the packet
        cut = $urandom_range(1, pkt_q.size());
        while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end
    end
    send_packet();
  endtask

  initial begin
    int start;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both limit registers
    apb_xfer(1'b0, REG_MAX_BODY, '0);
    apb_xfer(1'b0, REG_MAX_FIELD, '0);

    // ---- directed packets under the reset limits ----
    // lone byte flagged last, then one byte short of a header
    put_fill(1);
    send_packet();
    put_fill(17);
    send_packet();
    // bare header: header event and verdict come from the same byte
    put_header('0, '0, '0, '0, '0);
    send_packet();
    // all-ones cmd, txn and rsv words; padding at the allowance, then just over it
    put_header('1, '1, '0, '1, '0);
    put_fill(MAX_TRAILING);
    send_packet();
    put_header('1, '1, '0, '1, '0);
    put_fill(MAX_TRAILING + 1);
    send_packet();
    // body length all ones, then exactly at and just above the body limit
    put_header($urandom(), $urandom(), '1, $urandom(), '0);
    send_packet();
    put_header($urandom(), $urandom(), MAX_BODY_RST, $urandom(), '0);
    send_packet();
    put_header($urandom(), $urandom(), MAX_BODY_RST + 1, $urandom(), '0);
    send_packet();
    // one field over the field limit: still walked, still rejected
    put_header($urandom(), $urandom(), FIELD_HDR_BYTES, $urandom(),
               16'(MAX_FIELD_RST + 1));
    put_field($urandom(), '0, 0);
    send_packet();
    // fields declared but no room for even one field header
    put_header($urandom(), $urandom(), '0, $urandom(), MAX_FIELD_RST);
    send_packet();
    put_header($urandom(), $urandom(), 4, $urandom(), 1);
    put_fill(4);
    send_packet();
    // value longer than the body: field header reported, no value results follow
    put_header($urandom(), $urandom(), 8, $urandom(), 1);
    put_field('1, '1, 2);
    send_packet();
    // fields done but body left over, with and without any field
    put_header($urandom(), $urandom(), 12, $urandom(), 1);
    put_field('0, 2, 2);
    put_fill(4);
    send_packet();
    put_header($urandom(), $urandom(), 3, $urandom(), '0);
    put_fill(3);
    send_packet();
    // zero-length fields only
    put_header($urandom(), $urandom(), 2 * FIELD_HDR_BYTES, $urandom(), 2);
    put_field('1, '0, 0);
    put_field('0, '0, 0);
    send_packet();
    // well-formed, value bytes at both extremes, padding at the allowance
    put_header($urandom(), $urandom(), 2 * FIELD_HDR_BYTES + 3, $urandom(), 2);
    put_field(32'h8000_0001, 2, 0);
    put_be(16'h00FF, 2);
    put_field(32'h7FFF_FFFE, 1, 1);
    put_fill(MAX_TRAILING);
    send_packet();
    // buffer ends inside a value, then inside a field header
    put_header($urandom(), $urandom(), 10, $urandom(), 1);
    put_field($urandom(), 4, 2);
    send_packet();
    put_header($urandom(), $urandom(), FIELD_HDR_BYTES, $urandom(), 1);
    put_fill(3);
    send_packet();

    // ---- both limits at zero ----
    set_limits('0, '0);
    put_header($urandom(), $urandom(), '0, $urandom(), '0);
    send_packet();
    put_header($urandom(), $urandom(), FIELD_HDR_BYTES, $urandom(), 1);
    put_field($urandom(), '0, 0);
    send_packet();
    put_header($urandom(), $urandom(), 1, $urandom(), '0);
    put_fill(1);
    send_packet();

    // ---- random traffic, one limit setting per phase ----
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       set_limits('1, '1);  // upper bits beyond the registers too
        1:       set_limits($urandom_range(0, 40), $urandom_range(0, 3));
        2:       set_limits('0, '0);
        3:       set_limits(MAX_BODY_RST, MAX_FIELD_RST);
        default: set_limits($urandom(), $urandom());
      endcase
      // the reset-limit phase runs with no idling on either side
      calm  <= (ph == 3);
      start = n_bytes;
      while (n_bytes - start < PHASE_BYTES) send_random_packet();
    end

    drain();
    $display("sent %0d packets (%0d bytes) under seven limit settings", n_packets, n_bytes);
    $display("compared %0d results: headers, fields, value bytes and verdicts", n_checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
